// ===== rtl/lkv_pkg.sv =====
// Shared types and constants for the key-value cache.
package lkv_pkg;

    localparam int KEY_W   = 32;
    localparam int VALUE_W = 31;
    localparam int CAP_W   = 5;

    localparam logic [CAP_W-1:0] CAP_RESET  = 5'd16;
    localparam logic [KEY_W-1:0] MISS_VALUE = 32'hFFFF_FFFF;

    localparam logic FUNC_GET = 1'b0;
    localparam logic FUNC_SET = 1'b1;

    typedef logic [KEY_W-1:0]   key_t;
    typedef logic [VALUE_W-1:0] value_t;
    typedef logic [CAP_W-1:0]   cap_t;

    typedef struct packed {
        logic found;
        key_t read_value;
        logic evicted;
        key_t evicted_key;
    } result_t;

endpackage

// ===== rtl/lkv_store.sv =====
// Entry memory: key, value and recency rank per slot, one read and one write port.
module lkv_store #(
    parameter int ENTRIES = 16,
    parameter int IW      = 4,
    parameter int RW      = 4
) (
    input  logic            clk,
    input  logic            rd_en,
    input  logic [IW-1:0]   rd_addr,
    input  logic            wr_en,
    input  logic [IW-1:0]   wr_addr,
    input  lkv_pkg::key_t   wr_key,
    input  lkv_pkg::value_t wr_value,
    input  logic [RW-1:0]   wr_rank,
    output lkv_pkg::key_t   rd_key,
    output lkv_pkg::value_t rd_value,
    output logic [RW-1:0]   rd_rank
);
    import lkv_pkg::*;

    key_t          key_mem  [ENTRIES];
    value_t        val_mem  [ENTRIES];
    logic [RW-1:0] rank_mem [ENTRIES];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            key_mem[wr_addr]  <= wr_key;
            val_mem[wr_addr]  <= wr_value;
            rank_mem[wr_addr] <= wr_rank;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_key   <= key_mem[rd_addr];
            rd_value <= val_mem[rd_addr];
            rd_rank  <= rank_mem[rd_addr];
        end
    end

endmodule

// ===== rtl/lkv_ctrl.sv =====
// Sequencer: lookup pass, decision, rank update pass; holds valid bits and fill count.
module lkv_ctrl #(
    parameter int ENTRIES = 16,
    parameter int IW      = 4,
    parameter int RW      = 4,
    parameter int CW      = 5
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    output logic              busy,
    input  logic              func,
    input  lkv_pkg::key_t     key,
    input  lkv_pkg::value_t   value,
    input  lkv_pkg::cap_t     capacity,
    output logic              rd_en,
    output logic [IW-1:0]     rd_addr,
    output logic              wr_en,
    output logic [IW-1:0]     wr_addr,
    output lkv_pkg::key_t     wr_key,
    output lkv_pkg::value_t   wr_value,
    output logic [RW-1:0]     wr_rank,
    input  lkv_pkg::key_t     rd_key,
    input  lkv_pkg::value_t   rd_value,
    input  logic [RW-1:0]     rd_rank,
    output logic              done,
    output lkv_pkg::result_t  result
);
    import lkv_pkg::*;

    localparam int EW = (CW > CAP_W) ? CW + 1 : CAP_W + 1;

    typedef enum logic [1:0] {
        IDLE,
        SCAN,
        DECIDE,
        UPDATE
    } state_t;

    state_t          state_reg;
    logic [CW-1:0]   cnt_reg;
    logic            chk_vld_reg;
    logic [IW-1:0]   chk_idx_reg;
    logic [ENTRIES-1:0] valid_reg;
    logic [CW-1:0]   used_reg;
    logic            done_reg;
    result_t         result_reg;
    result_t         result_next;

    logic            op_func_reg;
    key_t            op_key_reg;
    value_t          op_value_reg;
    logic            hit_reg;
    logic [IW-1:0]   hit_idx_reg;
    logic [RW-1:0]   hit_rank_reg;
    value_t          hit_value_reg;
    logic            free_vld_reg;
    logic [IW-1:0]   free_idx_reg;
    logic            vic_vld_reg;
    logic [IW-1:0]   vic_idx_reg;
    logic [RW-1:0]   vic_rank_reg;
    key_t            vic_key_reg;
    logic [IW-1:0]   tgt_reg;
    logic [RW-1:0]   old_rank_reg;
    logic            age_all_reg;
    logic            write_kv_reg;

    logic            last_chk;
    logic            chk_valid;
    logic [EW-1:0]   cap_ext;
    logic [EW-1:0]   eff_cap;
    logic            has_room;

    assign busy      = (state_reg != IDLE);
    assign done      = done_reg;
    assign result    = result_reg;
    assign last_chk  = chk_vld_reg && (chk_idx_reg == IW'(ENTRIES - 1));
    assign chk_valid = valid_reg[chk_idx_reg];

    // Clamp the capacity register into 1 .. ENTRIES.
    always_comb
    begin
        cap_ext = EW'(capacity);
        priority if (cap_ext == '0)
            eff_cap = EW'(1);
        else if (cap_ext > EW'(ENTRIES))
            eff_cap = EW'(ENTRIES);
        else
            eff_cap = cap_ext;
    end

    assign has_room = (EW'(used_reg) < eff_cap);

    always_comb
    begin
        rd_en   = ((state_reg == SCAN) || (state_reg == UPDATE)) && (cnt_reg < CW'(ENTRIES));
        rd_addr = cnt_reg[IW-1:0];
    end

    // Reply fields from the lookup pass.
    always_comb
    begin
        result_next = '0;
        if (op_func_reg == FUNC_GET)
        begin
            if (hit_reg)
            begin
                result_next.found      = 1'b1;
                result_next.read_value = {1'b0, hit_value_reg};
            end
            else
                result_next.read_value = MISS_VALUE;
        end
        else if (hit_reg)
            result_next.found = 1'b1;
        else if (!has_room)
        begin
            result_next.evicted     = 1'b1;
            result_next.evicted_key = vic_key_reg;
        end
    end

    // Rank update pass: rewrite the target and each aged entry as it returns from memory.
    always_comb
    begin
        wr_en    = 1'b0;
        wr_addr  = chk_idx_reg;
        wr_key   = rd_key;
        wr_value = rd_value;
        wr_rank  = rd_rank;
        if ((state_reg == UPDATE) && chk_vld_reg)
        begin
            if (chk_idx_reg == tgt_reg)
            begin
                wr_en   = 1'b1;
                wr_rank = '0;
                if (write_kv_reg)
                begin
                    wr_key   = op_key_reg;
                    wr_value = op_value_reg;
                end
            end
            else if (chk_valid && (age_all_reg || (rd_rank < old_rank_reg)))
            begin
                wr_en   = 1'b1;
                wr_rank = rd_rank + RW'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= IDLE;
            cnt_reg     <= '0;
            chk_vld_reg <= 1'b0;
            chk_idx_reg <= '0;
            valid_reg   <= '0;
            used_reg    <= '0;
            done_reg    <= 1'b0;
            result_reg  <= '0;
        end
        else
        begin
            done_reg    <= (state_reg == DECIDE);
            chk_vld_reg <= rd_en;
            chk_idx_reg <= rd_addr;
            if (rd_en)
                cnt_reg <= cnt_reg + CW'(1);
            unique case (state_reg)
                IDLE:
                begin
                    cnt_reg <= '0;
                    if (start)
                        state_reg <= SCAN;
                end
                SCAN:
                begin
                    if (last_chk)
                        state_reg <= DECIDE;
                end
                DECIDE:
                begin
                    cnt_reg    <= '0;
                    result_reg <= result_next;
                    // A get miss changes nothing: skip the rank pass.
                    if ((op_func_reg == FUNC_GET) && !hit_reg)
                        state_reg <= IDLE;
                    else
                        state_reg <= UPDATE;
                end
                UPDATE:
                begin
                    // Fill of a free slot: mark it in use as it is written.
                    if (chk_vld_reg && (chk_idx_reg == tgt_reg) && !chk_valid)
                    begin
                        valid_reg[chk_idx_reg] <= 1'b1;
                        used_reg <= used_reg + CW'(1);
                    end
                    if (last_chk)
                        state_reg <= IDLE;
                end
                default:
                    state_reg <= IDLE;
            endcase
        end
    end

    // Item payload and lookup trackers.
    always_ff @(posedge clk)
    begin
        if ((state_reg == IDLE) && start)
        begin
            op_func_reg  <= func;
            op_key_reg   <= key;
            op_value_reg <= value;
            hit_reg      <= 1'b0;
            free_vld_reg <= 1'b0;
            vic_vld_reg  <= 1'b0;
        end
        if ((state_reg == SCAN) && chk_vld_reg)
        begin
            if (chk_valid && (rd_key == op_key_reg) && !hit_reg)
            begin
                hit_reg       <= 1'b1;
                hit_idx_reg   <= chk_idx_reg;
                hit_rank_reg  <= rd_rank;
                hit_value_reg <= rd_value;
            end
            if (!chk_valid && !free_vld_reg)
            begin
                free_vld_reg <= 1'b1;
                free_idx_reg <= chk_idx_reg;
            end
            if (chk_valid && (!vic_vld_reg || (rd_rank > vic_rank_reg)))
            begin
                vic_vld_reg  <= 1'b1;
                vic_idx_reg  <= chk_idx_reg;
                vic_rank_reg <= rd_rank;
                vic_key_reg  <= rd_key;
            end
        end
        if (state_reg == DECIDE)
        begin
            write_kv_reg <= (op_func_reg == FUNC_SET);
            if (hit_reg)
            begin
                tgt_reg      <= hit_idx_reg;
                old_rank_reg <= hit_rank_reg;
                age_all_reg  <= 1'b0;
            end
            else if (has_room)
            begin
                tgt_reg      <= free_idx_reg;
                old_rank_reg <= '0;
                age_all_reg  <= 1'b1;
            end
            else
            begin
                tgt_reg      <= vic_idx_reg;
                old_rank_reg <= vic_rank_reg;
                age_all_reg  <= 1'b0;
            end
        end
    end

    a_count_matches: assert property (@(posedge clk) disable iff (!rst_n)
        $countones(valid_reg) == int'(used_reg))
        else $error("fill count differs from number of valid slots");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        used_reg <= CW'(ENTRIES))
        else $error("fill count above entry count");

    a_done_after_decide: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> $past(state_reg == DECIDE))
        else $error("result strobe without a decision");

    a_no_port_clash: assert property (@(posedge clk) disable iff (!rst_n)
        (wr_en && rd_en) |-> (wr_addr != rd_addr))
        else $error("read and write hit the same slot in one cycle");

    a_fill_has_free: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == DECIDE) && (op_func_reg == FUNC_SET) && !hit_reg && has_room)
        |-> free_vld_reg)
        else $error("fill decided with no free slot");

endmodule

// ===== rtl/lru_key_value_cache.sv =====
// Top level of the fully associative LRU key-value cache.
//
//  channel   direction  handshake            payload
//  command   in         start & !busy        func, key, value
//  result    out        done (one cycle)     found, read_value, evicted, evicted_key
//  config    in         cfg_valid & ready    cfg_data (capacity)
//
// An item runs one lookup pass and one rank update pass over the single-read-port entry
// memory between acceptance and busy falling.
// The result strobes on done once the lookup pass is decided; a get miss ends there.
// Reset clears the valid bits and fill count at once; no clearing pass is run.
// The receiver cannot stall: done is high for one cycle only; the result fields hold until the next decision.
module lru_key_value_cache #(
    parameter int ENTRIES = 16
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    output logic                  busy,
    input  logic                  func,
    input  logic signed [31:0]    key,
    input  logic [30:0]           value,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [4:0]            cfg_data,
    output logic                  done,
    output logic                  found,
    output logic signed [31:0]    read_value,
    output logic                  evicted,
    output logic signed [31:0]    evicted_key
);
    import lkv_pkg::*;

    localparam int IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int RW = IW;
    localparam int CW = $clog2(ENTRIES + 1);

    cap_t          capacity_reg;
    logic          rd_en;
    logic [IW-1:0] rd_addr;
    logic          wr_en;
    logic [IW-1:0] wr_addr;
    key_t          wr_key;
    value_t        wr_value;
    logic [RW-1:0] wr_rank;
    key_t          rd_key;
    value_t        rd_value;
    logic [RW-1:0] rd_rank;
    result_t       result;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            capacity_reg <= CAP_RESET;
        else if (cfg_valid && cfg_ready)
            capacity_reg <= cfg_data;
    end

    lkv_store #(
        .ENTRIES (ENTRIES),
        .IW      (IW),
        .RW      (RW)
    ) u_store (
        .clk      (clk),
        .rd_en    (rd_en),
        .rd_addr  (rd_addr),
        .wr_en    (wr_en),
        .wr_addr  (wr_addr),
        .wr_key   (wr_key),
        .wr_value (wr_value),
        .wr_rank  (wr_rank),
        .rd_key   (rd_key),
        .rd_value (rd_value),
        .rd_rank  (rd_rank)
    );

    lkv_ctrl #(
        .ENTRIES (ENTRIES),
        .IW      (IW),
        .RW      (RW),
        .CW      (CW)
    ) u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (start),
        .busy     (busy),
        .func     (func),
        .key      (key_t'(key)),
        .value    (value),
        .capacity (capacity_reg),
        .rd_en    (rd_en),
        .rd_addr  (rd_addr),
        .wr_en    (wr_en),
        .wr_addr  (wr_addr),
        .wr_key   (wr_key),
        .wr_value (wr_value),
        .wr_rank  (wr_rank),
        .rd_key   (rd_key),
        .rd_value (rd_value),
        .rd_rank  (rd_rank),
        .done     (done),
        .result   (result)
    );

    assign found       = result.found;
    assign read_value  = $signed(result.read_value);
    assign evicted     = result.evicted;
    assign evicted_key = $signed(result.evicted_key);

endmodule
